// ----- rtl/rpm_pkg.sv -----
`timescale 1ns / 1ps

package rpm_pkg;

    // operation codes; codes 6 and 7 pass the pixel through
    typedef enum logic [2:0] {
        MODE_BRIGHTEN = 3'd0,
        MODE_OPAQUE   = 3'd1,
        MODE_KEY      = 3'd2,
        MODE_OPACITY  = 3'd3,
        MODE_INVERT   = 3'd4,
        MODE_MASK     = 3'd5
    } mode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_KEY_RED = 3'd1,
        REG_KEY_GRN = 3'd2,
        REG_KEY_BLU = 3'd3,
        REG_OPACITY = 3'd4,
        REG_INVERT  = 3'd5
    } cfg_idx_t;

    localparam int CHAN_W = 8;
    localparam int MODE_W = 3;
    localparam int INV_W  = 4;
    localparam int IDX_W  = 3;

    localparam logic [CHAN_W-1:0] CHAN_MAX      = 8'hff;
    localparam logic [CHAN_W-1:0] OPACITY_RESET = 8'hff;

    // invert_select bit positions
    localparam int INV_ALPHA = 3;
    localparam int INV_RED   = 2;
    localparam int INV_GREEN = 1;
    localparam int INV_BLUE  = 0;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAN_W-1:0] key_red;
        logic [CHAN_W-1:0] key_green;
        logic [CHAN_W-1:0] key_blue;
        logic [CHAN_W-1:0] opacity_ratio;
        logic [INV_W-1:0]  invert_select;
    } cfg_t;

endpackage

// ----- rtl/rgba_pixel_modifier.sv -----
`timescale 1ns / 1ps

// RGBA pixel modifier: one 8-bit RGBA pixel (plus a mask pixel) per request.
// Requests: a pixel is taken at a rising edge with start high and busy low.
//   busy is always low, so a new pixel may be given in every cycle.
// Results: out_red/green/blue/alpha are shown for exactly one cycle with done
//   high; each request passes the input register, then the result register
//   around one pass of combinational logic. Throughput is one pixel per
//   clock; the longest path is the 8x8 alpha multiply with its /255 fixup.
// Configuration: a separate cfg_valid/cfg_ready write channel, cfg_index
//   selects the register (0 mode, 1-3 key color, 4 opacity ratio, 5 invert
//   select), cfg_data carries the value. cfg_ready is always high. The user
//   must make writes only while no pixel is in flight; the block itself does
//   not enforce this. Unknown indexes are dropped.
// Reset: rst_n clears all in-flight requests and sets the registers to
//   brighten mode, key color black, opacity ratio 255, no inversion.
// The receiver cannot stall: every result must be taken when done is high.
module rgba_pixel_modifier (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [rpm_pkg::CHAN_W-1:0] pix_red,
    input  logic [rpm_pkg::CHAN_W-1:0] pix_green,
    input  logic [rpm_pkg::CHAN_W-1:0] pix_blue,
    input  logic [rpm_pkg::CHAN_W-1:0] pix_alpha,
    input  logic [rpm_pkg::CHAN_W-1:0] mask_red,
    input  logic [rpm_pkg::CHAN_W-1:0] mask_green,
    input  logic [rpm_pkg::CHAN_W-1:0] mask_blue,
    input  logic [rpm_pkg::CHAN_W-1:0] mask_alpha,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rpm_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rpm_pkg::CHAN_W-1:0] cfg_data,
    output logic                       done,
    output logic [rpm_pkg::CHAN_W-1:0] out_red,
    output logic [rpm_pkg::CHAN_W-1:0] out_green,
    output logic [rpm_pkg::CHAN_W-1:0] out_blue,
    output logic [rpm_pkg::CHAN_W-1:0] out_alpha
);
    import rpm_pkg::*;

    cfg_t   cfg;
    logic   in_valid_reg;
    pixel_t pix_reg;
    pixel_t mask_reg;
    pixel_t res_next;
    logic   out_valid_reg;
    pixel_t out_pix_reg;

    assign busy = 1'b0;

    rpm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input and result valid register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            pix_reg  <= '{red: pix_red, green: pix_green, blue: pix_blue, alpha: pix_alpha};
            mask_reg <= '{red: mask_red, green: mask_green, blue: mask_blue,
                          alpha: mask_alpha};
        end
    end

    rpm_pixel_op u_op (
        .cfg  (cfg),
        .pix  (pix_reg),
        .mask (mask_reg),
        .res  (res_next)
    );

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            out_pix_reg <= res_next;
        end
    end

    assign done      = out_valid_reg;
    assign out_red   = out_pix_reg.red;
    assign out_green = out_pix_reg.green;
    assign out_blue  = out_pix_reg.blue;
    assign out_alpha = out_pix_reg.alpha;

endmodule

// ----- rtl/rpm_cfg_regs.sv -----
`timescale 1ns / 1ps

module rpm_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [rpm_pkg::IDX_W-1:0] cfg_index,
    input  logic [rpm_pkg::CHAN_W-1:0] cfg_data,
    output rpm_pkg::cfg_t             cfg
);
    import rpm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // decode the register index; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_MODE:    cfg_next.mode          = cfg_data[MODE_W-1:0];
                REG_KEY_RED: cfg_next.key_red       = cfg_data;
                REG_KEY_GRN: cfg_next.key_green     = cfg_data;
                REG_KEY_BLU: cfg_next.key_blue      = cfg_data;
                REG_OPACITY: cfg_next.opacity_ratio = cfg_data;
                REG_INVERT:  cfg_next.invert_select = cfg_data[INV_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= MODE_BRIGHTEN;
            cfg_reg.key_red       <= '0;
            cfg_reg.key_green     <= '0;
            cfg_reg.key_blue      <= '0;
            cfg_reg.opacity_ratio <= OPACITY_RESET;
            cfg_reg.invert_select <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/rpm_pixel_op.sv -----
`timescale 1ns / 1ps

module rpm_pixel_op (
    input  rpm_pkg::cfg_t   cfg,
    input  rpm_pkg::pixel_t pix,
    input  rpm_pkg::pixel_t mask,
    output rpm_pkg::pixel_t res
);
    import rpm_pkg::*;

    logic [CHAN_W:0]     bright_r;
    logic [CHAN_W:0]     bright_g;
    logic [CHAN_W:0]     bright_b;
    logic [2*CHAN_W-1:0] prod;
    logic [CHAN_W-1:0]   quot_est;
    logic [CHAN_W:0]     rem;
    logic [CHAN_W-1:0]   opacity_alpha;
    logic                key_hit;

    // brighten: (255 + c) >> 1
    assign bright_r = {1'b0, pix.red}   + {1'b0, CHAN_MAX};
    assign bright_g = {1'b0, pix.green} + {1'b0, CHAN_MAX};
    assign bright_b = {1'b0, pix.blue}  + {1'b0, CHAN_MAX};

    // alpha * ratio / 255: p >> 8 is low by at most one,
    // remainder against 255 is (p & 0xff) + p >> 8
    assign prod          = pix.alpha * cfg.opacity_ratio;
    assign quot_est      = prod[2*CHAN_W-1:CHAN_W];
    assign rem           = {1'b0, prod[CHAN_W-1:0]} + {1'b0, quot_est};
    assign opacity_alpha = quot_est + {{(CHAN_W-1){1'b0}}, (rem >= {1'b0, CHAN_MAX})};

    assign key_hit = (pix.red == cfg.key_red) && (pix.green == cfg.key_green)
                     && (pix.blue == cfg.key_blue);

    // operation select
    always_comb
    begin
        res = pix;
        case (mode_t'(cfg.mode))
            MODE_BRIGHTEN:
            begin
                res.red   = bright_r[CHAN_W:1];
                res.green = bright_g[CHAN_W:1];
                res.blue  = bright_b[CHAN_W:1];
            end
            MODE_OPAQUE:
            begin
                res.alpha = CHAN_MAX;
            end
            MODE_KEY:
            begin
                if (key_hit)
                begin
                    res.alpha = '0;
                end
            end
            MODE_OPACITY:
            begin
                res.alpha = opacity_alpha;
            end
            MODE_INVERT:
            begin
                res.alpha = pix.alpha ^ {CHAN_W{cfg.invert_select[INV_ALPHA]}};
                res.red   = pix.red   ^ {CHAN_W{cfg.invert_select[INV_RED]}};
                res.green = pix.green ^ {CHAN_W{cfg.invert_select[INV_GREEN]}};
                res.blue  = pix.blue  ^ {CHAN_W{cfg.invert_select[INV_BLUE]}};
            end
            MODE_MASK:
            begin
                res = pix & mask;
            end
            default:
            begin
                res = pix;
            end
        endcase
    end

endmodule

// ----- rtl/rpm_checker.sv -----
`timescale 1ns / 1ps

module rpm_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cfg_ready,
    input logic done
);

    // every request yields a result through the input and result registers
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request without result");

    // no result without an earlier request
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without request");

    // pixel path never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // configuration registers always take a write
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready dropped");

endmodule

bind rgba_pixel_modifier rpm_checker u_rpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .done      (done)
);
